@@ hdl/mrqr_pkg.sv @@
// Package for the multi-ring queue router: field widths, operation and status codes,
// controller state type and parameter defaults.
// No dependencies.
package mrqr_pkg;

    // Fixed widths of the channel fields
    localparam int MODE_W   = 2;
    localparam int KEY_W    = 16;
    localparam int QID_W    = 3;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 3;

    // Parameter defaults
    localparam int NUM_QUEUES_DEF = 8;
    localparam int RING_DEPTH_DEF = 64;
    localparam int ITEM_WIDTH_DEF = 64;

    // Operation codes on the request channel
    localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OPEN = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    // Status codes on the response channel
    typedef enum logic [STATUS_W-1:0] {
        STAT_ENQ   = 3'd0,
        STAT_FULL  = 3'd1,
        STAT_DEQ   = 3'd2,
        STAT_EMPTY = 3'd3,
        STAT_OPEN  = 3'd4
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_PTR,
        ST_SLOT
    } state_t;

endpackage

@@ hdl/mrqr_req_if.sv @@
// Request channel of the multi-ring queue router: valid/ready plus operation fields.
// Depends on mrqr_pkg.
interface mrqr_req_if import mrqr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  route_key;
    logic [QID_W-1:0]  queue_num;
    logic [DATA_W-1:0] item_data;

    modport source (output valid, output mode, output route_key, output queue_num,
                    output item_data, input ready);
    modport sink   (input valid, input mode, input route_key, input queue_num,
                    input item_data, output ready);
endinterface

// Response channel of the multi-ring queue router: valid/ready plus result fields.
interface mrqr_rsp_if import mrqr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [QID_W-1:0]    target_queue;
    logic [DATA_W-1:0]   item_out;

    modport source (output valid, output status, output target_queue, output item_out,
                    input ready);
    modport sink   (input valid, input status, input target_queue, input item_out,
                    output ready);
endinterface

@@ hdl/multi_ring_queue_router_core.sv @@
// Top level of the multi-ring queue router: controller, pointer RAM with valid bits,
// shared slot RAM and output register. Depends on mrqr_pkg, mrqr_req_if/mrqr_rsp_if,
// mrqr_ram and mrqr_mod.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+----------------------------------------------
//  req     | in  | valid/ready | mode, route_key, queue_num, item_data
//  rsp     | out | valid/ready | status, target_queue, item_out
//
// An item passes from transfer through the reciprocal multiply and the pointer RAM read
// to its result (enqueue, open, empty dequeue); a dequeue that returns data also takes
// the slot RAM read before its result. req.ready is high in idle only.
// Reset clears the per-queue pointer valid bits at once; there is no clearing pass.
// A waiting result sits in the output register; the next item is taken meanwhile and
// holds in its final step until the output register frees up.
module multi_ring_queue_router_core import mrqr_pkg::*; #(
    parameter int NUM_QUEUES = NUM_QUEUES_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mrqr_req_if.sink   req,
    mrqr_rsp_if.source rsp
);

    localparam int QIDX_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int SLOT_DEPTH = NUM_QUEUES * RING_DEPTH;
    localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
    localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [SLOT_AW-1:0] RING_SZ  = SLOT_AW'(RING_DEPTH);

    state_t state_reg;
    state_t state_next;

    logic [MODE_W-1:0]     mode_reg;
    logic [ITEM_WIDTH-1:0] data_reg;
    logic [QIDX_W-1:0]     q_reg;
    logic [SLOT_AW-1:0]    slot_addr_reg;
    logic [SLOT_AW-1:0]    slot_addr_next;
    logic [NUM_QUEUES-1:0] ptr_vld_reg;

    logic              accept;
    logic              mod_load;
    logic [KEY_W-1:0]  mod_value;
    logic [QIDX_W-1:0] mod_rem;

    logic               ptr_we;
    logic [QIDX_W-1:0]  ptr_addr;
    logic [2*PTR_W-1:0] ptr_wdata;
    logic [2*PTR_W-1:0] ptr_rdata;

    logic                  slot_we;
    logic [SLOT_AW-1:0]    slot_waddr;
    logic [SLOT_AW-1:0]    slot_raddr;
    logic [ITEM_WIDTH-1:0] slot_rdata;

    logic [PTR_W-1:0]   head;
    logic [PTR_W-1:0]   tail;
    logic [PTR_W-1:0]   head_nx;
    logic [PTR_W-1:0]   tail_nx;
    logic               is_full;
    logic               is_empty;
    logic [SLOT_AW-1:0] q_base;
    logic [SLOT_AW-1:0] addr_head;
    logic [SLOT_AW-1:0] addr_tail;

    logic                out_vld_reg;
    status_t             out_status_reg;
    logic [QID_W-1:0]    out_queue_reg;
    logic [DATA_W-1:0]   out_item_reg;
    logic                out_free;
    logic                res_load;
    status_t             res_status;
    logic [DATA_W-1:0]   res_item;
    logic [KEY_W-1:0]    q_wide;

    // Queue select: key for enqueue, queue id for the others, both reduced mod count
    assign accept    = req.valid && req.ready;
    assign mod_load  = accept;
    assign mod_value = (req.mode == MODE_ENQ) ? req.route_key : KEY_W'(req.queue_num);

    mrqr_mod #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_mod (
        .clk   (clk),
        .load  (mod_load),
        .value (mod_value),
        .rem   (mod_rem)
    );

    // Per-queue pointers: {head, tail}
    mrqr_ram #(
        .WIDTH (2 * PTR_W),
        .DEPTH (NUM_QUEUES)
    ) u_ptr_ram (
        .clk   (clk),
        .we    (ptr_we),
        .waddr (q_reg),
        .wdata (ptr_wdata),
        .raddr (ptr_addr),
        .rdata (ptr_rdata)
    );

    // Shared slot store
    mrqr_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (data_reg),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // Decode pointers; a queue never written since reset reads as empty
    always_comb
    begin
        head     = ptr_vld_reg[q_reg] ? ptr_rdata[2*PTR_W-1:PTR_W] : '0;
        tail     = ptr_vld_reg[q_reg] ? ptr_rdata[PTR_W-1:0] : '0;
        head_nx  = (head == PTR_LAST) ? '0 : head + 1'b1;
        tail_nx  = (tail == PTR_LAST) ? '0 : tail + 1'b1;
        is_full  = (tail_nx == head);
        is_empty = (head == tail);
        q_base    = SLOT_AW'(q_reg) * RING_SZ;
        addr_head = q_base + SLOT_AW'(head);
        addr_tail = q_base + SLOT_AW'(tail);
    end

    assign out_free = !out_vld_reg || rsp.ready;
    assign q_wide   = KEY_W'(q_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.mode != MODE_NONE)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                state_next = ST_PTR;
            end
            ST_PTR:
            begin
                if (mode_reg == MODE_DEQ && !is_empty)
                begin
                    state_next = ST_SLOT;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SLOT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller
    always_comb
    begin
        req.ready      = 1'b0;
        ptr_addr       = q_reg;
        ptr_we         = 1'b0;
        ptr_wdata      = {head, tail};
        slot_we        = 1'b0;
        slot_waddr     = addr_tail;
        slot_raddr     = slot_addr_reg;
        slot_addr_next = slot_addr_reg;
        res_load       = 1'b0;
        res_status     = STAT_ENQ;
        res_item       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_MOD:
            begin
                ptr_addr = mod_rem;
            end
            ST_PTR:
            begin
                case (mode_reg)
                    MODE_DEQ:
                    begin
                        if (is_empty)
                        begin
                            res_load   = out_free;
                            res_status = STAT_EMPTY;
                        end
                        else
                        begin
                            // Pop now, fetch the word in the next cycle
                            ptr_we         = 1'b1;
                            ptr_wdata      = {head_nx, tail};
                            slot_raddr     = addr_head;
                            slot_addr_next = addr_head;
                        end
                    end
                    MODE_OPEN:
                    begin
                        res_load   = out_free;
                        res_status = STAT_OPEN;
                        ptr_we     = out_free;
                        ptr_wdata  = '0;
                    end
                    default:
                    begin
                        res_load   = out_free;
                        res_status = is_full ? STAT_FULL : STAT_ENQ;
                        ptr_we     = out_free && !is_full;
                        ptr_wdata  = {head, tail_nx};
                        slot_we    = out_free && !is_full;
                    end
                endcase
            end
            ST_SLOT:
            begin
                res_load   = out_free;
                res_status = STAT_DEQ;
                res_item   = DATA_W'(slot_rdata);
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ptr_vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ptr_we)
            begin
                ptr_vld_reg[q_reg] <= 1'b1;
            end
            if (res_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            data_reg <= req.item_data[ITEM_WIDTH-1:0];
        end
        if (state_reg == ST_MOD)
        begin
            q_reg <= mod_rem;
        end
        slot_addr_reg <= slot_addr_next;
        if (res_load)
        begin
            out_status_reg <= res_status;
            out_queue_reg  <= q_wide[QID_W-1:0];
            out_item_reg   <= res_item;
        end
    end

    // Drive the response channel from the output register
    assign rsp.valid        = out_vld_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.target_queue = out_queue_reg;
    assign rsp.item_out     = out_item_reg;

    // Word fetch only follows a dequeue pointer step
    a_slot_from_deq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SLOT && $past(state_reg) != ST_SLOT)
            |-> ($past(state_reg) == ST_PTR && mode_reg == MODE_DEQ))
        else $error("slot fetch state entered without a dequeue");

    // Slot writes come only from a committed enqueue
    a_slot_write: assert property (@(posedge clk) disable iff (!rst_n)
        slot_we |-> (state_reg == ST_PTR && mode_reg == MODE_ENQ && res_load))
        else $error("slot write outside an enqueue commit");

    // Item word is zero unless the result is a dequeue
    a_item_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_status_reg != STAT_DEQ) |-> (out_item_reg == '0))
        else $error("nonzero item on a non-dequeue result");

endmodule

@@ hdl/mrqr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module mrqr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/mrqr_mod.sv @@
// Remainder of a 16-bit value by the queue count: reciprocal multiply, registered,
// then back-multiply with one compare-and-subtract correction. Depends on mrqr_pkg.
module mrqr_mod import mrqr_pkg::*; #(
    parameter int NUM_QUEUES = NUM_QUEUES_DEF,
    localparam int QIDX_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
    input  logic              clk,
    input  logic              load,
    input  logic [KEY_W-1:0]  value,
    output logic [QIDX_W-1:0] rem
);

    localparam int M_W    = KEY_W + 1;
    localparam int PROD_W = KEY_W + M_W;
    localparam int RECIP_I = (2 ** KEY_W) / NUM_QUEUES;
    localparam logic [M_W-1:0]   RECIP = M_W'(RECIP_I);
    localparam logic [KEY_W-1:0] NQ    = KEY_W'(NUM_QUEUES);

    logic [KEY_W-1:0]   val_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [KEY_W-1:0]   quot_est;
    logic [2*KEY_W-1:0] back_full;
    logic [KEY_W-1:0]   rem_raw;
    logic [KEY_W-1:0]   rem_fix;

    // Stage one: multiply by the truncated reciprocal
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg  <= value;
            prod_reg <= PROD_W'(value) * PROD_W'(RECIP);
        end
    end

    // Stage two: estimate is low by at most one, so one correction step suffices
    always_comb
    begin
        quot_est  = prod_reg[2*KEY_W-1:KEY_W];
        back_full = quot_est * NQ;
        rem_raw   = val_reg - back_full[KEY_W-1:0];
        rem_fix   = (rem_raw >= NQ) ? (rem_raw - NQ) : rem_raw;
        rem       = rem_fix[QIDX_W-1:0];
    end

endmodule
